FILE: hdl/wds_pkg.sv
// shared types and constants of the weighted discrete sampler
`default_nettype none
package wds_pkg;

  localparam int NUM_VALUES  = 16;
  localparam int INDEX_BITS  = 4;
  localparam int WEIGHT_BITS = 16;
  localparam int RAND_BITS   = 16;
  localparam int SUM_BITS    = 20;
  localparam int LEVELS      = 4;
  localparam int LVL_BITS    = 2;
  localparam int PROD_BITS   = RAND_BITS + SUM_BITS;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_WRITE   = 4'b0010,
    ST_DESCEND = 4'b0100,
    ST_FINISH  = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic write_en;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic req_mode;
    logic empty;
    logic last_level;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: hdl/wds_if.sv
// request and result channel interfaces
`default_nettype none
interface wds_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [wds_pkg::INDEX_BITS-1:0]   index;
  logic [wds_pkg::WEIGHT_BITS-1:0]  weight;
  logic [wds_pkg::RAND_BITS-1:0]    rand_level0;
  logic [wds_pkg::RAND_BITS-1:0]    rand_level1;
  logic [wds_pkg::RAND_BITS-1:0]    rand_level2;
  logic [wds_pkg::RAND_BITS-1:0]    rand_level3;

  modport source (output valid, mode, index, weight, rand_level0, rand_level1,
                  rand_level2, rand_level3, input ready);
  modport sink   (input valid, mode, index, weight, rand_level0, rand_level1,
                  rand_level2, rand_level3, output ready);
endinterface

interface wds_out_if;
  logic                           valid;
  logic                           ready;
  logic [wds_pkg::INDEX_BITS-1:0] chosen_value;
  logic                           empty_flag;
  logic [wds_pkg::SUM_BITS-1:0]   total_weight;

  modport source (output valid, chosen_value, empty_flag, total_weight, input ready);
  modport sink   (input valid, chosen_value, empty_flag, total_weight, output ready);
endinterface
`default_nettype wire

FILE: hdl/wds_ctrl.sv
// controller state machine of the sampler
`default_nettype none
module wds_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire wds_pkg::dp_status_t status,
  output wds_pkg::dp_cmd_t         cmd
);
  import wds_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_emit;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign can_emit  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.req_mode == MODE_WRITE) begin
            state_nxt = ST_WRITE;
          end else if (status.empty) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_DESCEND;
          end
        end
      end
      ST_WRITE: begin
        cmd.write_en = 1'b1;
        state_nxt    = ST_FINISH;
      end
      ST_DESCEND: begin
        cmd.step = 1'b1;
        if (status.last_level) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (can_emit) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/wds_dp.sv
// datapath: weight table, level sums, descent and result register
`default_nettype none
module wds_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_mode,
  input  wire logic [wds_pkg::INDEX_BITS-1:0]      in_index,
  input  wire logic [wds_pkg::WEIGHT_BITS-1:0]     in_weight,
  input  wire logic [wds_pkg::RAND_BITS-1:0]       in_rand0,
  input  wire logic [wds_pkg::RAND_BITS-1:0]       in_rand1,
  input  wire logic [wds_pkg::RAND_BITS-1:0]       in_rand2,
  input  wire logic [wds_pkg::RAND_BITS-1:0]       in_rand3,
  input  wire wds_pkg::dp_cmd_t                    cmd,
  output wds_pkg::dp_status_t                      status,
  output logic [wds_pkg::INDEX_BITS-1:0]           out_chosen,
  output logic                                     out_empty,
  output logic [wds_pkg::SUM_BITS-1:0]             out_total
);
  import wds_pkg::*;

  // request registers
  logic                   mode_r;
  logic [INDEX_BITS-1:0]  idx_r;
  logic [WEIGHT_BITS-1:0] wt_r;
  logic [RAND_BITS-1:0]   rand_r [LEVELS];

  // tree storage, one array per level, leaves are the weights
  logic [WEIGHT_BITS-1:0] weights_r [NUM_VALUES];
  logic [SUM_BITS-1:0]    root_r;
  logic [SUM_BITS-1:0]    lvl1_r [2];
  logic [SUM_BITS-1:0]    lvl2_r [4];
  logic [SUM_BITS-1:0]    lvl3_r [8];

  // descent
  logic [LVL_BITS-1:0]    lvl_r;
  logic [INDEX_BITS-1:0]  pos_r;

  // result
  logic [INDEX_BITS-1:0]  chosen_r;
  logic                   empty_r;
  logic [SUM_BITS-1:0]    total_r;

  logic [SUM_BITS-1:0]    delta;
  logic [SUM_BITS-1:0]    here;
  logic [SUM_BITS-1:0]    left;
  logic [RAND_BITS-1:0]   frac;
  logic [PROD_BITS-1:0]   prod;
  logic [PROD_BITS-1:0]   left_sh;
  logic                   go_left;

  assign delta = {{(SUM_BITS-WEIGHT_BITS){1'b0}}, wt_r}
               - {{(SUM_BITS-WEIGHT_BITS){1'b0}}, weights_r[idx_r]};

  always_comb begin
    case (lvl_r)
      2'd0: begin
        here = root_r;
        left = lvl1_r[0];
      end
      2'd1: begin
        here = lvl1_r[pos_r[0]];
        left = lvl2_r[{pos_r[0], 1'b0}];
      end
      2'd2: begin
        here = lvl2_r[pos_r[1:0]];
        left = lvl3_r[{pos_r[1:0], 1'b0}];
      end
      2'd3: begin
        here = lvl3_r[pos_r[2:0]];
        left = {{(SUM_BITS-WEIGHT_BITS){1'b0}}, weights_r[{pos_r[2:0], 1'b0}]};
      end
      default: begin
        here = '0;
        left = '0;
      end
    endcase
  end

  assign frac    = rand_r[lvl_r];
  assign prod    = {{SUM_BITS{1'b0}}, frac} * {{RAND_BITS{1'b0}}, here};
  assign left_sh = {left, {RAND_BITS{1'b0}}};
  assign go_left = (prod < left_sh);

  assign status.req_mode   = in_mode;
  assign status.empty      = (root_r == '0);
  assign status.last_level = (lvl_r == LVL_BITS'(LEVELS - 1));

  assign out_chosen = chosen_r;
  assign out_empty  = empty_r;
  assign out_total  = total_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_mode;
      idx_r     <= in_index;
      wt_r      <= in_weight;
      rand_r[0] <= in_rand0;
      rand_r[1] <= in_rand1;
      rand_r[2] <= in_rand2;
      rand_r[3] <= in_rand3;
    end
    if (cmd.emit) begin
      chosen_r <= (mode_r == MODE_SAMPLE) ? pos_r : '0;
      empty_r  <= (root_r == '0);
      total_r  <= root_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0;
      pos_r <= '0;
    end else if (cmd.load) begin
      lvl_r <= '0;
      pos_r <= '0;
    end else if (cmd.step) begin
      lvl_r <= lvl_r + LVL_BITS'(1);
      pos_r <= {pos_r[INDEX_BITS-2:0], !go_left};
    end
  end

  // path update by the weight difference, modulo the sum width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
      for (int i = 0; i < NUM_VALUES; i++) weights_r[i] <= '0;
      for (int i = 0; i < 2; i++) lvl1_r[i] <= '0;
      for (int i = 0; i < 4; i++) lvl2_r[i] <= '0;
      for (int i = 0; i < 8; i++) lvl3_r[i] <= '0;
    end else if (cmd.write_en) begin
      weights_r[idx_r]      <= wt_r;
      root_r                <= root_r + delta;
      lvl1_r[idx_r[3]]      <= lvl1_r[idx_r[3]] + delta;
      lvl2_r[idx_r[3:2]]    <= lvl2_r[idx_r[3:2]] + delta;
      lvl3_r[idx_r[3:1]]    <= lvl3_r[idx_r[3:1]] + delta;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/weighted_discrete_sampler_core.sv
// top level of the weighted discrete sampler
// Holds sixteen 16-bit weights in a sum tree. A request with mode 0 writes
// one weight; a request with mode 1 walks the tree one level per cycle,
// one 16x20 multiply and compare per level, and skips the walk when all
// weights are zero. Every request gives one result with the chosen index, an
// empty flag and the total weight. The input is taken again while the last
// result still waits in the output register.
`default_nettype none
module weighted_discrete_sampler_core (
  input  wire logic clk,
  input  wire logic rst_n,
  wds_in_if.sink    in_ch,
  wds_out_if.source out_ch
);
  import wds_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  wds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  wds_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mode    (in_ch.mode),
    .in_index   (in_ch.index),
    .in_weight  (in_ch.weight),
    .in_rand0   (in_ch.rand_level0),
    .in_rand1   (in_ch.rand_level1),
    .in_rand2   (in_ch.rand_level2),
    .in_rand3   (in_ch.rand_level3),
    .cmd        (cmd),
    .status     (status),
    .out_chosen (out_ch.chosen_value),
    .out_empty  (out_ch.empty_flag),
    .out_total  (out_ch.total_weight)
  );

endmodule
`default_nettype wire

FILE: hdl/wds_chk.sv
// port checker of the sampler and its bind
`default_nettype none
module wds_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [wds_pkg::INDEX_BITS-1:0] out_chosen,
  input wire logic                           out_empty,
  input wire logic [wds_pkg::SUM_BITS-1:0]   out_total
);
  import wds_pkg::*;

  a_no_valid_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total))
    else $error("stalled result dropped or changed");

  a_empty_matches_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty == (out_total == '0)))
    else $error("empty flag disagrees with total");

  a_empty_no_choice: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty |-> (out_chosen == '0))
    else $error("index chosen from an empty table");

endmodule

bind weighted_discrete_sampler_core wds_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_chosen (out_ch.chosen_value),
  .out_empty  (out_ch.empty_flag),
  .out_total  (out_ch.total_weight)
);
`default_nettype wire

FILE: verif/tb_weighted_discrete_sampler_core.sv
// testbench of the weighted discrete sampler: directed and random requests checked against a sum-tree predictor
`timescale 1ns / 100ps
module tb_weighted_discrete_sampler_core;
  import wds_pkg::*;

  localparam int CLK_HALF         = 10;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int TAIL_CYCLES      = 20;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int MAX_PRINTS       = 100;

  localparam logic [RAND_BITS-1:0]   FRAC_ZERO  = '0;
  localparam logic [RAND_BITS-1:0]   FRAC_MAX   = '1;
  localparam logic [RAND_BITS-1:0]   FRAC_HALF  = RAND_BITS'(1) << (RAND_BITS - 1);
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1);

  typedef logic [LEVELS-1:0][RAND_BITS-1:0] frac_set_t;

  typedef struct packed {
    logic                   mode;
    logic [INDEX_BITS-1:0]  index;
    logic [WEIGHT_BITS-1:0] weight;
    frac_set_t              frac;
  } request_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] chosen;
    logic                  empty;
    logic [SUM_BITS-1:0]   total;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  wds_in_if  in_ch ();
  wds_out_if out_ch ();

  weighted_discrete_sampler_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #CLK_HALF clk = ~clk;

  logic [WEIGHT_BITS-1:0] weight_shadow [NUM_VALUES];
  result_t                pending_results [$];
  int                     error_count = 0;
  int                     cycle_count = 0;
  bit                     idle_on     = 1'b1;
  bit                     hold_go     = 1'b0;
  logic                   sink_hold;

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [63:0] range_sum(input int unsigned lo, input int unsigned cnt);
    logic [63:0] acc;
    acc = '0;
    for (int unsigned i = lo; i < lo + cnt; i++) acc += 64'(weight_shadow[i]);
    return acc;
  endfunction

  // stores a write, then walks the tree exactly as the hardware compares
  function automatic result_t predict_result(input request_t req);
    result_t     res;
    logic [63:0] sum_all, here, left;
    int unsigned lo, cnt, half;
    res = '0;
    if (req.mode == MODE_WRITE) weight_shadow[req.index] = req.weight;
    sum_all   = range_sum(0, NUM_VALUES);
    res.total = SUM_BITS'(sum_all);
    res.empty = (sum_all == 0);
    if (req.mode == MODE_SAMPLE && sum_all != 0) begin
      lo  = 0;
      cnt = NUM_VALUES;
      for (int lv = 0; cnt > 1; lv++) begin
        half = cnt / 2;
        here = range_sum(lo, cnt);
        left = range_sum(lo, half);
        if (64'(req.frac[lv % LEVELS]) * here < (left << RAND_BITS)) begin
          cnt = half;
        end else begin
          lo  += half;
          cnt -= half;
        end
      end
      res.chosen = INDEX_BITS'(lo);
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [RAND_BITS-1:0] rand_frac();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return FRAC_ZERO;
    if (roll < 20) return FRAC_MAX;
    if (roll < 25) return FRAC_HALF;
    return RAND_BITS'($urandom);
  endfunction

  function automatic frac_set_t rand_fracs();
    frac_set_t f;
    for (int lv = 0; lv < LEVELS; lv++) f[lv] = rand_frac();
    return f;
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] rand_weight();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return '0;
    if (roll < 30) return WEIGHT_MAX;
    if (roll < 50) return WEIGHT_BITS'($urandom_range(1, 15));
    return WEIGHT_BITS'($urandom);
  endfunction

  function automatic request_t make_request(input logic mode, input int idx,
                                            input logic [WEIGHT_BITS-1:0] w,
                                            input frac_set_t f);
    request_t req;
    req.mode   = mode;
    req.index  = INDEX_BITS'(idx);
    req.weight = w;
    req.frac   = f;
    return req;
  endfunction

  function automatic request_t rand_request();
    logic mode;
    mode = ($urandom_range(0, 99) < 45) ? MODE_WRITE : MODE_SAMPLE;
    return make_request(mode, $urandom_range(0, NUM_VALUES - 1), rand_weight(), rand_fracs());
  endfunction

  // valid stays high into the next request when no gap is drawn
  task automatic send_request(input request_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= req.mode;
    in_ch.index       <= req.index;
    in_ch.weight      <= req.weight;
    in_ch.rand_level0 <= req.frac[0];
    in_ch.rand_level1 <= req.frac[1];
    in_ch.rand_level2 <= req.frac[2];
    in_ch.rand_level3 <= req.frac[3];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_result(req));
  endtask

  task automatic compare_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: value %0d empty %0b total %0d",
                                got.chosen, got.empty, got.total));
      return;
    end
    want = pending_results.pop_front();
    if (got.chosen !== want.chosen)
      report_mismatch($sformatf("chosen_value %0d, expected %0d", got.chosen, want.chosen));
    if (got.empty !== want.empty)
      report_mismatch($sformatf("empty_flag %0b, expected %0b", got.empty, want.empty));
    if (got.total !== want.total)
      report_mismatch($sformatf("total_weight %0d, expected %0d", got.total, want.total));
  endtask

  initial begin : result_sink
    int      stall_left;
    result_t got;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.chosen = out_ch.chosen_value;
        got.empty  = out_ch.empty_flag;
        got.total  = out_ch.total_weight;
        compare_result(got);
      end
      if (!rst_n || sink_hold) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        out_ch.ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin : long_hold
    sink_hold <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic test_empty_table();
    send_request(make_request(MODE_SAMPLE, 3, WEIGHT_MAX, {LEVELS{FRAC_ZERO}}));
    send_request(make_request(MODE_SAMPLE, 12, WEIGHT_ONE, {LEVELS{FRAC_MAX}}));
    send_request(make_request(MODE_WRITE, 5, '0, {LEVELS{FRAC_HALF}}));
  endtask

  // zero-weight subtrees must never be entered
  task automatic test_single_weight();
    send_request(make_request(MODE_WRITE, 9, WEIGHT_ONE, {LEVELS{FRAC_ZERO}}));
    send_request(make_request(MODE_SAMPLE, 0, '0, {LEVELS{FRAC_ZERO}}));
    send_request(make_request(MODE_SAMPLE, 0, '0, {LEVELS{FRAC_MAX}}));
    send_request(make_request(MODE_SAMPLE, 0, '0, {LEVELS{FRAC_HALF}}));
    send_request(make_request(MODE_WRITE, 9, '0, {LEVELS{FRAC_MAX}}));
  endtask

  // fraction times sum equal to left sum goes right, one below goes left
  task automatic test_split_boundary();
    send_request(make_request(MODE_WRITE, 0, WEIGHT_ONE, {LEVELS{FRAC_ZERO}}));
    send_request(make_request(MODE_WRITE, 8, WEIGHT_ONE, {LEVELS{FRAC_ZERO}}));
    send_request(make_request(MODE_SAMPLE, 0, '0, {LEVELS{FRAC_HALF}}));
    send_request(make_request(MODE_SAMPLE, 0, '0, {LEVELS{FRAC_HALF - 1'b1}}));
  endtask

  task automatic test_weight_extremes();
    send_request(make_request(MODE_WRITE, 0, WEIGHT_MAX, {LEVELS{FRAC_ZERO}}));
    send_request(make_request(MODE_WRITE, 15, WEIGHT_MAX, {LEVELS{FRAC_ZERO}}));
    send_request(make_request(MODE_WRITE, 8, '0, {LEVELS{FRAC_ZERO}}));
    send_request(make_request(MODE_SAMPLE, 7, '0, {LEVELS{FRAC_ZERO}}));
    send_request(make_request(MODE_SAMPLE, 7, '0, {LEVELS{FRAC_MAX}}));
    send_request(make_request(MODE_SAMPLE, 7, '0, {FRAC_MAX, FRAC_ZERO, FRAC_HALF, FRAC_MAX}));
    send_request(make_request(MODE_WRITE, 0, '0, {LEVELS{FRAC_MAX}}));
    send_request(make_request(MODE_WRITE, 15, '0, {LEVELS{FRAC_MAX}}));
    send_request(make_request(MODE_SAMPLE, 15, WEIGHT_MAX, {LEVELS{FRAC_HALF}}));
  endtask

  // random mix, with a periodic fill of the whole table to reach full and empty totals
  task automatic test_random_traffic(input int n_items);
    logic [WEIGHT_BITS-1:0] fill;
    int                     roll;
    for (int i = 0; i < n_items; i++) begin
      if (i % 200 == 100) begin
        roll = $urandom_range(0, 2);
        fill = (roll == 0) ? '0 : (roll == 1) ? WEIGHT_MAX : rand_weight();
        for (int k = 0; k < NUM_VALUES; k++)
          send_request(make_request(MODE_WRITE, k, fill, rand_fracs()));
        i += NUM_VALUES;
      end
      send_request(rand_request());
    end
  endtask

  task automatic test_back_pressure(input int n_items);
    idle_on = 1'b0;
    hold_go = 1'b1;
    for (int i = 0; i < n_items; i++) send_request(rand_request());
    idle_on = 1'b1;
  endtask

  task automatic test_back_to_back(input int n_items);
    idle_on = 1'b0;
    test_random_traffic(n_items);
    idle_on = 1'b1;
  endtask

  initial begin : main_seq
    for (int i = 0; i < NUM_VALUES; i++) weight_shadow[i] = '0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_WRITE;
    in_ch.index       <= '0;
    in_ch.weight      <= '0;
    in_ch.rand_level0 <= '0;
    in_ch.rand_level1 <= '0;
    in_ch.rand_level2 <= '0;
    in_ch.rand_level3 <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_single_weight();
    test_split_boundary();
    test_weight_extremes();
    test_random_traffic(600);
    test_back_pressure(40);
    test_back_to_back(150);
    test_random_traffic(600);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/wds_pkg.sv
hdl/wds_if.sv
hdl/wds_ctrl.sv
hdl/wds_dp.sv
hdl/weighted_discrete_sampler_core.sv
hdl/wds_chk.sv
verif/tb_weighted_discrete_sampler_core.sv
